FILE: sv/assert_macros.svh
// Assertion macros shared by the nearest light select RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NLS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NLS_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define NLS_ASSERT(lbl, clk, rst, prop, msg)
`define NLS_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

FILE: sv/nls_pkg.sv
// Types and constants of the nearest light select block.
package nls_pkg;

   localparam int MAX_LIGHTS = 16;
   localparam int MAX_OUT    = 16;
   localparam int IDX_W      = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
   localparam int CNT_W      = $clog2(MAX_LIGHTS + 1);
   localparam int COORD_W    = 16;
   localparam int ID_W       = 8;
   localparam int MAG_W      = 16;
   localparam int PROD_W     = 2 * MAG_W;
   localparam int DIST_W     = 34;
   localparam int LIMIT_W    = 5;
   localparam int EMIT_W     = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_ADD   = 2'd1;
   localparam logic [1:0] ACT_QUERY = 2'd2;

   // coordinate fed to the squaring unit, last step only sums
   localparam logic [1:0] STEP_X   = 2'd0;
   localparam logic [1:0] STEP_Y   = 2'd1;
   localparam logic [1:0] STEP_Z   = 2'd2;
   localparam logic [1:0] STEP_SUM = 2'd3;

   typedef struct packed {
      logic [1:0]                 action;
      logic [ID_W-1:0]            light_id;
      logic signed [COORD_W-1:0]  pos_x;
      logic signed [COORD_W-1:0]  pos_y;
      logic signed [COORD_W-1:0]  pos_z;
      logic [LIMIT_W-1:0]         max_count;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]   found_id;
      logic [DIST_W-1:0] distance_sq;
      logic              valid_res;
      logic              last;
      logic              table_full_error;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]            ident;
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic signed [COORD_W-1:0]  z;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic add;
   } tbl_ctrl_type;

endpackage

FILE: sv/nls_req_if.sv
// Request channel interface: valid, ready and one request item.
interface nls_req_if;
   logic             valid;
   logic             ready;
   nls_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/nls_rsp_if.sv
// Response channel interface: valid, ready and one response item.
interface nls_rsp_if;
   logic             valid;
   logic             ready;
   nls_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/nls_sqdiff_unit.sv
// Shared squared-difference unit: |a - b| squared, registered.
module nls_sqdiff_unit (
   input  logic                                 clock,
   input  logic signed [nls_pkg::COORD_W-1:0]   coord_a,
   input  logic signed [nls_pkg::COORD_W-1:0]   coord_b,
   output logic [nls_pkg::PROD_W-1:0]           prod
);

   logic signed [nls_pkg::COORD_W:0] diff;
   logic [nls_pkg::COORD_W:0]        diff_neg;
   logic [nls_pkg::MAG_W-1:0]        mag;
   logic [nls_pkg::PROD_W-1:0]       prod_ff;

   always_comb begin
      diff     = {coord_a[nls_pkg::COORD_W-1], coord_a} - {coord_b[nls_pkg::COORD_W-1], coord_b};
      diff_neg = -diff;
      // magnitude never exceeds 16 bits for two 16-bit operands
      mag      = diff[nls_pkg::COORD_W] ? diff_neg[nls_pkg::MAG_W-1:0]
                                        : diff[nls_pkg::MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= mag * mag;
   end

   assign prod = prod_ff;

endmodule

FILE: sv/nls_entry_table.sv
// Light entry table: id and position store with fill count.
module nls_entry_table (
   input  logic                           clock,
   input  logic                           reset,
   input  nls_pkg::tbl_ctrl_type          ctrl,
   input  nls_pkg::entry_type             wr_entry,
   input  logic [nls_pkg::IDX_W-1:0]      rd_idx,
   output nls_pkg::entry_type             rd_entry,
   output logic [nls_pkg::CNT_W-1:0]      count,
   output logic                           full
);

   nls_pkg::entry_type              entry_ff [nls_pkg::MAX_LIGHTS];
   logic [nls_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [nls_pkg::IDX_W-1:0]       wr_idx;

   assign full   = (count_ff >= nls_pkg::CNT_W'(nls_pkg::MAX_LIGHTS));
   assign wr_idx = nls_pkg::IDX_W'(count_ff);

   always_comb begin
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (ctrl.add && !full) begin
         count_in = count_ff + nls_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.add && !ctrl.clear && !full) begin
         entry_ff[wr_idx] <= wr_entry;
      end
   end

   assign rd_entry = entry_ff[rd_idx];
   assign count    = count_ff;

endmodule

FILE: sv/nearest_light_select.sv
// Top level of the nearest light select block: sequencer, distance store and channels.
// A clear or add returns one acknowledge item; an unused action is taken and dropped.
// A query on n stored lights that returns k items runs one squared-difference
// multiplier over every entry in the steps X, Y, Z and sum, then finds each result
// by a compare scan over all n entries and loads it into the response register,
// holding while that register is still full. The request side is not ready while
// a query runs.
module nearest_light_select (
   input  logic      clock,
   input  logic      reset,
   nls_req_if.sink   req_bus,
   nls_rsp_if.source rsp_bus
);

`include "assert_macros.svh"

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_DIST = 4'b0010,
      S_SCAN = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   logic [nls_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic [1:0]                         step_ff, step_in;
   logic [nls_pkg::DIST_W-1:0]         acc_ff, acc_in;
   logic [nls_pkg::IDX_W-1:0]          scan_ff, scan_in;
   logic [nls_pkg::IDX_W-1:0]          best_idx_ff, best_idx_in;
   logic [nls_pkg::DIST_W-1:0]         best_dist_ff, best_dist_in;
   logic                               best_found_ff, best_found_in;
   logic [nls_pkg::MAX_LIGHTS-1:0]     taken_ff, taken_in;
   logic [nls_pkg::EMIT_W-1:0]         emit_ff, emit_in;
   logic [nls_pkg::EMIT_W-1:0]         out_cnt_ff, out_cnt_in;
   logic signed [nls_pkg::COORD_W-1:0] qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;
   nls_pkg::rsp_type                   rsp_data_ff, rsp_data_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [nls_pkg::DIST_W-1:0]         dist_ff [nls_pkg::MAX_LIGHTS];
   logic                               dist_wr_en;
   logic [nls_pkg::DIST_W-1:0]         dist_wr_data;

   nls_pkg::tbl_ctrl_type              tbl_ctrl;
   nls_pkg::entry_type                 wr_entry, rd_entry;
   logic [nls_pkg::IDX_W-1:0]          rd_idx;
   logic [nls_pkg::CNT_W-1:0]          count;
   logic                               full;

   logic signed [nls_pkg::COORD_W-1:0] coord_a, coord_b;
   logic [nls_pkg::PROD_W-1:0]         prod;

   logic                               req_fire, rsp_free;
   logic [nls_pkg::EMIT_W-1:0]         cnt_ext, lim_ext, req_emit_a, req_emit;
   logic [nls_pkg::DIST_W-1:0]         cur_dist;
   logic                               cand, idx_last, scan_last, out_last;

   nls_entry_table u_table (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (tbl_ctrl),
      .wr_entry (wr_entry),
      .rd_idx   (rd_idx),
      .rd_entry (rd_entry),
      .count    (count),
      .full     (full)
   );

   nls_sqdiff_unit u_sqdiff (
      .clock   (clock),
      .coord_a (coord_a),
      .coord_b (coord_b),
      .prod    (prod)
   );

   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE) && rsp_free;
   assign req_fire      = req_bus.valid && req_bus.ready;

   assign wr_entry.ident = req_bus.payload.light_id;
   assign wr_entry.x     = req_bus.payload.pos_x;
   assign wr_entry.y     = req_bus.payload.pos_y;
   assign wr_entry.z     = req_bus.payload.pos_z;

   assign rd_idx = (state_ff == S_OUT) ? best_idx_ff : idx_ff;

   // number of items a query returns: min(count, limit, MAX_OUT)
   always_comb begin
      cnt_ext    = nls_pkg::EMIT_W'(count);
      lim_ext    = nls_pkg::EMIT_W'(req_bus.payload.max_count);
      req_emit_a = (cnt_ext < lim_ext) ? cnt_ext : lim_ext;
      req_emit   = (req_emit_a > nls_pkg::EMIT_W'(nls_pkg::MAX_OUT))
                   ? nls_pkg::EMIT_W'(nls_pkg::MAX_OUT) : req_emit_a;
   end

   always_comb begin
      case (step_ff)
         nls_pkg::STEP_X: begin
            coord_a = rd_entry.x;
            coord_b = qx_ff;
         end
         nls_pkg::STEP_Y: begin
            coord_a = rd_entry.y;
            coord_b = qy_ff;
         end
         nls_pkg::STEP_Z: begin
            coord_a = rd_entry.z;
            coord_b = qz_ff;
         end
         default: begin
            coord_a = '0;
            coord_b = '0;
         end
      endcase
   end

   assign cur_dist     = dist_ff[scan_ff];
   assign dist_wr_data = acc_ff + nls_pkg::DIST_W'(prod);
   assign idx_last     = (nls_pkg::CNT_W'(idx_ff) + nls_pkg::CNT_W'(1)) == count;
   assign scan_last    = (nls_pkg::CNT_W'(scan_ff) + nls_pkg::CNT_W'(1)) == count;
   assign out_last     = (out_cnt_ff + nls_pkg::EMIT_W'(1)) == emit_ff;
   // strict compare keeps the earlier entry on a tie
   assign cand = !taken_ff[scan_ff] && (!best_found_ff || (cur_dist < best_dist_ff));

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      acc_in        = acc_ff;
      scan_in       = scan_ff;
      best_idx_in   = best_idx_ff;
      best_dist_in  = best_dist_ff;
      best_found_in = best_found_ff;
      taken_in      = taken_ff;
      emit_in       = emit_ff;
      out_cnt_in    = out_cnt_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      qz_in         = qz_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in   = rsp_data_ff;
      tbl_ctrl      = '0;
      dist_wr_en    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_bus.payload.action)
                  nls_pkg::ACT_CLEAR: begin
                     tbl_ctrl.clear   = 1'b1;
                     rsp_valid_in     = 1'b1;
                     rsp_data_in      = '0;
                     rsp_data_in.last = 1'b1;
                  end
                  nls_pkg::ACT_ADD: begin
                     tbl_ctrl.add                 = 1'b1;
                     rsp_valid_in                 = 1'b1;
                     rsp_data_in                  = '0;
                     rsp_data_in.last             = 1'b1;
                     rsp_data_in.table_full_error = full;
                  end
                  nls_pkg::ACT_QUERY: begin
                     if (req_emit == '0) begin
                        rsp_valid_in     = 1'b1;
                        rsp_data_in      = '0;
                        rsp_data_in.last = 1'b1;
                     end else begin
                        qx_in      = req_bus.payload.pos_x;
                        qy_in      = req_bus.payload.pos_y;
                        qz_in      = req_bus.payload.pos_z;
                        emit_in    = req_emit;
                        out_cnt_in = '0;
                        taken_in   = '0;
                        idx_in     = '0;
                        step_in    = nls_pkg::STEP_X;
                        state_in   = S_DIST;
                     end
                  end
                  default: begin
                     // unused action: drop the item
                  end
               endcase
            end
         end
         S_DIST: begin
            case (step_ff)
               nls_pkg::STEP_X: begin
                  step_in = nls_pkg::STEP_Y;
               end
               nls_pkg::STEP_Y: begin
                  acc_in  = nls_pkg::DIST_W'(prod);
                  step_in = nls_pkg::STEP_Z;
               end
               nls_pkg::STEP_Z: begin
                  acc_in  = acc_ff + nls_pkg::DIST_W'(prod);
                  step_in = nls_pkg::STEP_SUM;
               end
               default: begin
                  dist_wr_en = 1'b1;
                  step_in    = nls_pkg::STEP_X;
                  if (idx_last) begin
                     scan_in       = '0;
                     best_found_in = 1'b0;
                     state_in      = S_SCAN;
                  end else begin
                     idx_in = idx_ff + nls_pkg::IDX_W'(1);
                  end
               end
            endcase
         end
         S_SCAN: begin
            if (cand) begin
               best_dist_in  = cur_dist;
               best_idx_in   = scan_ff;
               best_found_in = 1'b1;
            end
            if (scan_last) begin
               state_in = S_OUT;
            end else begin
               scan_in = scan_ff + nls_pkg::IDX_W'(1);
            end
         end
         S_OUT: begin
            // hold until the response register frees up
            if (rsp_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.found_id         = rd_entry.ident;
               rsp_data_in.distance_sq      = best_dist_ff;
               rsp_data_in.valid_res        = 1'b1;
               rsp_data_in.last             = out_last;
               rsp_data_in.table_full_error = 1'b0;
               taken_in[best_idx_ff]        = 1'b1;
               out_cnt_in                   = out_cnt_ff + nls_pkg::EMIT_W'(1);
               if (out_last) begin
                  state_in = S_IDLE;
               end else begin
                  scan_in       = '0;
                  best_found_in = 1'b0;
                  state_in      = S_SCAN;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      step_ff       <= step_in;
      acc_ff        <= acc_in;
      scan_ff       <= scan_in;
      best_idx_ff   <= best_idx_in;
      best_dist_ff  <= best_dist_in;
      best_found_ff <= best_found_in;
      taken_ff      <= taken_in;
      emit_ff       <= emit_in;
      out_cnt_ff    <= out_cnt_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      qz_ff         <= qz_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (dist_wr_en) begin
         dist_ff[idx_ff] <= dist_wr_data;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

   `NLS_ASSERT(a_out_below_emit, clock, reset,
      (state_ff == S_SCAN || state_ff == S_OUT) |-> (out_cnt_ff < emit_ff),
      "result count reached the limit inside a query")
   `NLS_ASSERT(a_out_has_winner, clock, reset, (state_ff == S_OUT) |-> best_found_ff,
      "scan ended without a candidate entry")
   `NLS_ASSERT(a_taken_tracks_out, clock, reset,
      (state_ff == S_SCAN) |-> ($countones(taken_ff) == out_cnt_ff),
      "taken mask out of step with result count")
   `NLS_NEVER(a_emit_within_table, clock, reset,
      (state_ff != S_IDLE) && (emit_ff > nls_pkg::EMIT_W'(count)),
      "query returns more items than stored lights")

endmodule
